// ===== rtl/core/bst_pkg.sv =====
// Shared types and constants for the byte stream tokenizer.
// Holds token codes, character codes, the keyword table and the result record.
// No dependencies.
package bst_pkg;

    localparam int POS_W        = 24;
    localparam int CNT_W        = 16;
    localparam int LEN_W        = 16;
    localparam int VAL_W        = 31;
    localparam int TYPE_W       = 5;
    localparam int KW_CHARS     = 8;
    localparam int KW_COUNT     = 8;
    localparam int KW_LEN_W     = $clog2(KW_CHARS + 2);
    localparam int KW_IDX_W     = $clog2(KW_CHARS);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_RESULTS  = 2;

    // Token type codes
    localparam logic [TYPE_W-1:0] TT_EOF      = 5'd0;
    localparam logic [TYPE_W-1:0] TT_LPAREN   = 5'd1;
    localparam logic [TYPE_W-1:0] TT_RPAREN   = 5'd2;
    localparam logic [TYPE_W-1:0] TT_LBRACE   = 5'd3;
    localparam logic [TYPE_W-1:0] TT_RBRACE   = 5'd4;
    localparam logic [TYPE_W-1:0] TT_SEMI     = 5'd5;
    localparam logic [TYPE_W-1:0] TT_COLON    = 5'd6;
    localparam logic [TYPE_W-1:0] TT_COMMA    = 5'd7;
    localparam logic [TYPE_W-1:0] TT_DOLLAR   = 5'd8;
    localparam logic [TYPE_W-1:0] TT_BANG     = 5'd9;
    localparam logic [TYPE_W-1:0] TT_NE       = 5'd10;
    localparam logic [TYPE_W-1:0] TT_ASSIGN   = 5'd11;
    localparam logic [TYPE_W-1:0] TT_EQ       = 5'd12;
    localparam logic [TYPE_W-1:0] TT_STRING   = 5'd13;
    localparam logic [TYPE_W-1:0] TT_NUMBER   = 5'd14;
    localparam logic [TYPE_W-1:0] TT_BINARY   = 5'd15;
    localparam logic [TYPE_W-1:0] TT_IDENT    = 5'd16;
    localparam logic [TYPE_W-1:0] TT_KW_FIRST = 5'd17;
    localparam logic [TYPE_W-1:0] TT_BAD_CHAR = 5'd25;
    localparam logic [TYPE_W-1:0] TT_TOO_BIG  = 5'd26;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keyword text, first character in the top byte
    typedef logic [KW_CHARS*8-1:0] t_kw_text;
    typedef logic [KW_CHARS-1:0][7:0] t_kw_buf;

    localparam t_kw_text KW_TEXT [KW_COUNT] = '{
        t_kw_text'("bitgroup") << ((KW_CHARS - 8) * 8),
        t_kw_text'("enum")     << ((KW_CHARS - 4) * 8),
        t_kw_text'("header")   << ((KW_CHARS - 6) * 8),
        t_kw_text'("include")  << ((KW_CHARS - 7) * 8),
        t_kw_text'("opcode")   << ((KW_CHARS - 6) * 8),
        t_kw_text'("type")     << ((KW_CHARS - 4) * 8),
        t_kw_text'("true")     << ((KW_CHARS - 4) * 8),
        t_kw_text'("false")    << ((KW_CHARS - 5) * 8)
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        KW_LEN_W'(8), KW_LEN_W'(4), KW_LEN_W'(6), KW_LEN_W'(7),
        KW_LEN_W'(6), KW_LEN_W'(4), KW_LEN_W'(4), KW_LEN_W'(5)
    };

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_COMMENT = 8'b0000_0010,
        M_DEC     = 8'b0000_0100,
        M_BIN     = 8'b0000_1000,
        M_IDENT   = 8'b0001_0000,
        M_BANG    = 8'b0010_0000,
        M_EQ      = 8'b0100_0000,
        M_STR     = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic [TYPE_W-1:0] tok_code;
        logic [POS_W-1:0]  start_offset;
        logic [LEN_W-1:0]  token_length;
        logic [CNT_W-1:0]  line_number;
        logic [CNT_W-1:0]  column_number;
        logic [VAL_W-1:0]  number_value;
        logic              last_of_run;
    } t_token;

    // Identifier or keyword code for the buffered identifier text
    function automatic logic [TYPE_W-1:0] f_ident_type(input t_kw_buf buf_text,
                                                      input logic [KW_LEN_W-1:0] len);
        logic [TYPE_W-1:0] code;
        logic              match;
        code = TT_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            match = (len == KW_LEN[k]);
            for (int i = 0; i < KW_CHARS; i++) begin
                if ((KW_LEN_W'(i) < KW_LEN[k]) &&
                    (buf_text[i] != KW_TEXT[k][(KW_CHARS-1-i)*8 +: 8])) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                code = TYPE_W'(TT_KW_FIRST + TYPE_W'(k));
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/byte_stream_tokenizer.sv =====
// Byte stream tokenizer: scans source bytes into tokens in one pass per byte.
// Depends on bst_pkg for codes, the keyword table and the token record.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_kind, i_source_byte
//  result    out        o_valid / i_stall    o_tok_code .. o_last_of_run
//
// One byte or end item is taken per cycle while o_stall is low; its tokens are queued the same cycle.
// A result appears on the output at the earliest in the cycle after its item is taken.
// A four-entry result queue absorbs the up to two results of an item; input
// stalls while fewer than two entries are free.
// Reset is synchronous; the scanner and the queue are ready right after it.
module byte_stream_tokenizer
    import bst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [7:0]          i_source_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [TYPE_W-1:0]   o_tok_code,
    output logic [POS_W-1:0]    o_start_offset,
    output logic [LEN_W-1:0]    o_token_length,
    output logic [CNT_W-1:0]    o_line_number,
    output logic [CNT_W-1:0]    o_column_number,
    output logic [VAL_W-1:0]    o_number_value,
    output logic                o_last_of_run
);

    // Scanner state
    t_mode                r_mode, n_mode;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [POS_W-1:0]     r_tstart, n_tstart;
    logic [CNT_W-1:0]     r_line, n_line;
    logic [CNT_W-1:0]     r_col, n_col;
    logic [VAL_W-1:0]     r_acc, n_acc;
    logic                 r_ovf, n_ovf;
    logic                 r_quote, n_quote;
    logic [KW_LEN_W-1:0]  r_idlen, n_idlen;
    logic [LEN_W-1:0]     r_toklen, n_toklen;
    t_kw_buf              r_kw_buf;
    logic                 kw_we;
    logic [KW_IDX_W-1:0]  kw_widx;

    // Result queue
    t_token                r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  push, pop;
    logic [FIFO_PTR_W-1:0] wr_b;
    t_token                out_tok;

    // Per-item decode
    logic [7:0]            b;
    logic                  is_digit, is_ident, taken, pending;
    logic [CNT_W-1:0]      col_inc, line_inc;
    logic [LEN_W-1:0]      len_inc;
    logic [VAL_W+3:0]      dec_next;
    logic                  a_v, b_v;
    t_token                tok_a, tok_b;

    assign b        = i_source_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_ident = ((b >= CH_LO_A) && (b <= CH_LO_Z)) ||
                      ((b >= CH_UP_A) && (b <= CH_UP_Z)) || (b == CH_UNDER);
    assign col_inc  = (r_col == '1) ? r_col : r_col + 1'b1;
    assign line_inc = (r_line == '1) ? r_line : r_line + 1'b1;
    assign len_inc  = (r_toklen == '1) ? r_toklen : r_toklen + 1'b1;
    assign dec_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (VAL_W+4)'(b - CH_ZERO);

    assign push = i_valid && !o_stall;
    assign pop  = o_valid && !i_stall;

    // Does the pending token absorb this byte
    always_comb begin
        unique case (r_mode)
            M_COMMENT: taken = (b != CH_LF);
            M_DEC:     taken = is_digit || ((b == CH_LO_B) && (r_toklen == LEN_W'(1)) &&
                                            (r_acc == '0) && !r_ovf);
            M_BIN:     taken = (b == CH_ZERO) || (b == CH_ONE);
            M_IDENT:   taken = is_ident;
            M_BANG,
            M_EQ:      taken = (b == CH_EQUAL);
            M_STR:     taken = 1'b1;
            default:   taken = 1'b0;
        endcase
    end

    // Token that a non-continuing byte or the end item flushes out
    always_comb begin
        tok_a              = '0;
        tok_a.start_offset = r_tstart;
        tok_a.token_length = r_toklen;
        tok_a.line_number  = r_line;
        tok_a.column_number = r_col;
        pending            = 1'b1;
        unique case (r_mode)
            M_DEC: begin
                tok_a.tok_code     = r_ovf ? TT_TOO_BIG : TT_NUMBER;
                tok_a.number_value = r_ovf ? '0 : r_acc;
            end
            M_BIN: begin
                tok_a.tok_code     = r_ovf ? TT_TOO_BIG : TT_BINARY;
                tok_a.number_value = r_ovf ? '0 : r_acc;
            end
            M_IDENT: tok_a.tok_code = f_ident_type(r_kw_buf, r_idlen);
            M_BANG:  tok_a.tok_code = TT_BANG;
            M_EQ:    tok_a.tok_code = TT_ASSIGN;
            M_STR:   tok_a.tok_code = TT_STRING;
            default: pending = 1'b0;
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_line   = r_line;
        n_col    = r_col;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_quote  = r_quote;
        n_idlen  = r_idlen;
        n_toklen = r_toklen;
        kw_we    = 1'b0;
        kw_widx  = r_idlen[KW_IDX_W-1:0];
        a_v      = 1'b0;
        b_v      = 1'b0;
        tok_b               = '0;
        tok_b.start_offset  = r_pos;
        tok_b.line_number   = r_line;
        tok_b.column_number = col_inc;

        if (i_kind) begin
            a_v    = pending;
            b_v    = 1'b1;
            tok_b.tok_code = TT_EOF;
            n_col  = col_inc;
            n_mode = M_IDLE;
        end else if (taken) begin
            n_pos    = r_pos + 1'b1;
            n_col    = col_inc;
            n_toklen = len_inc;
            tok_b.start_offset = r_tstart;
            tok_b.token_length = len_inc;
            unique case (r_mode)
                M_DEC: begin
                    if (!is_digit) begin
                        n_mode = M_BIN;
                    end else if (!r_ovf) begin
                        if (dec_next[VAL_W+3:VAL_W] != '0) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = dec_next[VAL_W-1:0];
                        end
                    end
                end
                M_BIN: begin
                    if (!r_ovf) begin
                        if (r_acc[VAL_W-1]) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = {r_acc[VAL_W-2:0], b[0]};
                        end
                    end
                end
                M_IDENT: begin
                    kw_we = (r_idlen < KW_LEN_W'(KW_CHARS));
                    if (r_idlen <= KW_LEN_W'(KW_CHARS)) begin
                        n_idlen = r_idlen + 1'b1;
                    end
                end
                M_BANG, M_EQ: begin
                    b_v    = 1'b1;
                    tok_b.tok_code = (r_mode == M_BANG) ? TT_NE : TT_EQ;
                    n_mode = M_IDLE;
                end
                M_STR: begin
                    if (b == (r_quote ? CH_SQUOTE : CH_DQUOTE)) begin
                        b_v    = 1'b1;
                        tok_b.tok_code = TT_STRING;
                        n_mode = M_IDLE;
                    end
                end
                default: ;
            endcase
        end else begin
            // Flush the pending token, then start a new one on this byte
            a_v      = pending;
            n_tstart = r_pos;
            n_pos    = r_pos + 1'b1;
            n_toklen = LEN_W'(1);
            n_col    = col_inc;
            n_mode   = M_IDLE;
            tok_b.token_length = LEN_W'(1);
            unique case (b) inside
                CH_LF: begin
                    n_line = line_inc;
                    n_col  = CNT_W'(1);
                end
                CH_SPACE, CH_TAB, CH_CR: ;
                CH_HASH:   n_mode = M_COMMENT;
                [CH_ZERO:CH_NINE]: begin
                    n_acc  = VAL_W'(b - CH_ZERO);
                    n_ovf  = 1'b0;
                    n_mode = M_DEC;
                end
                [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER: begin
                    kw_we   = 1'b1;
                    kw_widx = '0;
                    n_idlen = KW_LEN_W'(1);
                    n_mode  = M_IDENT;
                end
                CH_LPAREN: begin b_v = 1'b1; tok_b.tok_code = TT_LPAREN; end
                CH_RPAREN: begin b_v = 1'b1; tok_b.tok_code = TT_RPAREN; end
                CH_LBRACE: begin b_v = 1'b1; tok_b.tok_code = TT_LBRACE; end
                CH_RBRACE: begin b_v = 1'b1; tok_b.tok_code = TT_RBRACE; end
                CH_SEMI:   begin b_v = 1'b1; tok_b.tok_code = TT_SEMI;   end
                CH_COLON:  begin b_v = 1'b1; tok_b.tok_code = TT_COLON;  end
                CH_COMMA:  begin b_v = 1'b1; tok_b.tok_code = TT_COMMA;  end
                CH_DOLLAR: begin b_v = 1'b1; tok_b.tok_code = TT_DOLLAR; end
                CH_BANG:   n_mode = M_BANG;
                CH_EQUAL:  n_mode = M_EQ;
                CH_DQUOTE, CH_SQUOTE: begin
                    n_quote = (b == CH_SQUOTE);
                    n_mode  = M_STR;
                end
                default: begin
                    b_v = 1'b1;
                    tok_b.tok_code = TT_BAD_CHAR;
                end
            endcase
        end
        tok_a.last_of_run = !b_v;
        tok_b.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_line   <= CNT_W'(1);
            r_col    <= CNT_W'(1);
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_quote  <= 1'b0;
            r_idlen  <= '0;
            r_toklen <= '0;
        end else if (push) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_line   <= n_line;
            r_col    <= n_col;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_quote  <= n_quote;
            r_idlen  <= n_idlen;
            r_toklen <= n_toklen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !i_kind && kw_we) begin
            r_kw_buf[kw_widx] <= b;
        end
    end

    // Result queue: up to two writes per item, one read per cycle while i_stall is low
    assign wr_b = r_wr + FIFO_PTR_W'(a_v);

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (a_v) begin
                r_fifo[r_wr] <= tok_a;
            end
            if (b_v) begin
                r_fifo[wr_b] <= tok_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + FIFO_PTR_W'(a_v) + FIFO_PTR_W'(b_v);
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (push ? FIFO_CNT_W'(a_v) + FIFO_CNT_W'(b_v) : '0)
                     - FIFO_CNT_W'(pop);
        end
    end

    assign o_stall = (r_count > FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign o_valid = (r_count != '0);
    assign out_tok = r_fifo[r_rd];

    assign o_tok_code      = out_tok.tok_code;
    assign o_start_offset  = out_tok.start_offset;
    assign o_token_length  = out_tok.token_length;
    assign o_line_number   = out_tok.line_number;
    assign o_column_number = out_tok.column_number;
    assign o_number_value  = out_tok.number_value;
    assign o_last_of_run   = out_tok.last_of_run;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_end_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_kind) |=> (r_mode == M_IDLE))
        else $error("scanner not idle after end item");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_kind && !pop) |=> (r_count > $past(r_count)))
        else $error("end item queued no result");

    a_counters_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != '0) && (r_col != '0))
        else $error("line or column counter reached zero");

endmodule

// ===== tb/bst_tb_pkg.sv =====
// Token ledger for the byte stream tokenizer testbench: a bit-true shadow of the
// scanner that predicts every token, and the queue of tokens still awaited.
// Depends on bst_pkg for token codes, character codes and the token record.
package bst_tb_pkg;
    import bst_pkg::*;

    localparam logic        KIND_BYTE = 1'b0;
    localparam logic        KIND_END  = 1'b1;
    localparam int unsigned VALUE_MAX = 32'h7FFF_FFFF;

    string keyword_text [KW_COUNT] = '{
        "bitgroup", "enum", "header", "include", "opcode", "type", "true", "false"
    };

    logic [7:0] punct_marks [8] = '{
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI, CH_COLON, CH_COMMA, CH_DOLLAR
    };

    class token_ledger;
        t_mode              mode;
        logic [POS_W-1:0]   byte_pos;
        logic [POS_W-1:0]   tok_start;
        logic [CNT_W-1:0]   line_cnt;
        logic [CNT_W-1:0]   col_cnt;
        logic [LEN_W-1:0]   tok_len;
        int unsigned        acc;
        bit                 ovf;
        bit                 single_quote;
        logic [7:0]         id_chars [KW_CHARS];
        int unsigned        id_len;
        t_token             awaited_tokens [$];
        t_token             item_tokens [$];
        int                 errors;

        function new();
            mode         = M_IDLE;
            byte_pos     = '0;
            tok_start    = '0;
            line_cnt     = 1;
            col_cnt      = 1;
            tok_len      = '0;
            acc          = 0;
            ovf          = 1'b0;
            single_quote = 1'b0;
            id_len       = 0;
            errors       = 0;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        function bit is_letter(logic [7:0] b);
            return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
                   b == CH_UNDER;
        endfunction

        // Consume one byte: position wraps, column and length saturate.
        function void bump();
            byte_pos++;
            if (col_cnt != '1) col_cnt++;
            if (tok_len != '1) tok_len++;
        endfunction

        function void push_token(logic [TYPE_W-1:0] code, int unsigned value,
                                 logic [POS_W-1:0] start, logic [LEN_W-1:0] len);
            t_token t;
            if (item_tokens.size() >= MAX_RESULTS) return;
            t.tok_code      = code;
            t.start_offset  = start;
            t.token_length  = len;
            t.line_number   = line_cnt;
            t.column_number = col_cnt;
            t.number_value  = value[VAL_W-1:0];
            t.last_of_run   = 1'b0;
            item_tokens.push_back(t);
        endfunction

        function void close_token(logic [TYPE_W-1:0] code, int unsigned value);
            push_token(code, value, tok_start, tok_len);
            mode = M_IDLE;
        endfunction

        function logic [TYPE_W-1:0] word_code();
            bit hit;
            for (int k = 0; k < KW_COUNT; k++) begin
                if (id_len == keyword_text[k].len()) begin
                    hit = 1'b1;
                    for (int i = 0; i < keyword_text[k].len(); i++) begin
                        if (id_chars[i] != keyword_text[k][i]) hit = 1'b0;
                    end
                    if (hit) return TYPE_W'(TT_KW_FIRST + k);
                end
            end
            return TT_IDENT;
        endfunction

        function void flush_word();
            case (mode)
                M_DEC:   close_token(ovf ? TT_TOO_BIG : TT_NUMBER, ovf ? 0 : acc);
                M_BIN:   close_token(ovf ? TT_TOO_BIG : TT_BINARY, ovf ? 0 : acc);
                M_IDENT: close_token(word_code(), 0);
                M_BANG:  close_token(TT_BANG, 0);
                M_EQ:    close_token(TT_ASSIGN, 0);
                M_STR:   close_token(TT_STRING, 0);
                default: mode = M_IDLE;
            endcase
        endfunction

        function void start_token(logic [7:0] b);
            tok_start = byte_pos;
            tok_len   = '0;
            // LF between tokens: next line, column restarts after the bump
            if (b == CH_LF) begin
                if (line_cnt != '1) line_cnt++;
                col_cnt = '0;
            end
            bump();
            if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) return;
            if (b == CH_HASH) begin
                mode = M_COMMENT;
                return;
            end
            if (is_digit(b)) begin
                acc  = b - CH_ZERO;
                ovf  = 1'b0;
                mode = M_DEC;
                return;
            end
            if (is_letter(b)) begin
                id_chars[0] = b;
                id_len      = 1;
                mode        = M_IDENT;
                return;
            end
            for (int k = 0; k < 8; k++) begin
                if (b == punct_marks[k]) begin
                    close_token(TYPE_W'(TT_LPAREN + k), 0);
                    return;
                end
            end
            if (b == CH_BANG) begin
                mode = M_BANG;
                return;
            end
            if (b == CH_EQUAL) begin
                mode = M_EQ;
                return;
            end
            if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                single_quote = (b == CH_SQUOTE);
                mode         = M_STR;
                return;
            end
            close_token(TT_BAD_CHAR, 0);
        endfunction

        // Returns 1 when the pending token takes the byte.
        function bit extend_token(logic [7:0] b);
            int unsigned d;
            d = b - CH_ZERO;
            case (mode)
                M_COMMENT: begin
                    if (b == CH_LF) begin
                        mode = M_IDLE;
                        return 1'b0;
                    end
                    bump();
                    return 1'b1;
                end
                M_DEC: begin
                    if (is_digit(b)) begin
                        if (!ovf) begin
                            if (acc > (VALUE_MAX - d) / 10) ovf = 1'b1;
                            else acc = acc * 10 + d;
                        end
                        bump();
                        return 1'b1;
                    end
                    // only a lone leading zero turns into a binary prefix
                    if (b == CH_LO_B && tok_len == 1 && acc == 0 && !ovf) begin
                        mode = M_BIN;
                        bump();
                        return 1'b1;
                    end
                    return 1'b0;
                end
                M_BIN: begin
                    if (b == CH_ZERO || b == CH_ONE) begin
                        if (!ovf) begin
                            if (acc[30]) ovf = 1'b1;
                            else acc = (acc << 1) | d;
                        end
                        bump();
                        return 1'b1;
                    end
                    return 1'b0;
                end
                M_IDENT: begin
                    if (is_letter(b)) begin
                        if (id_len < KW_CHARS) id_chars[id_len] = b;
                        if (id_len <= KW_CHARS) id_len++;
                        bump();
                        return 1'b1;
                    end
                    return 1'b0;
                end
                M_BANG, M_EQ: begin
                    if (b == CH_EQUAL) begin
                        bump();
                        close_token(mode == M_BANG ? TT_NE : TT_EQ, 0);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                M_STR: begin
                    // LF inside a string advances the column only
                    bump();
                    if (b == (single_quote ? CH_SQUOTE : CH_DQUOTE)) close_token(TT_STRING, 0);
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_item(logic kind, logic [7:0] b);
            t_token t;
            item_tokens.delete();
            if (kind == KIND_END) begin
                flush_word();
                if (col_cnt != '1) col_cnt++;
                push_token(TT_EOF, 0, byte_pos, '0);
            end else if (!extend_token(b)) begin
                flush_word();
                start_token(b);
            end
            if (item_tokens.size() > 0) begin
                t = item_tokens.pop_back();
                t.last_of_run = 1'b1;
                item_tokens.push_back(t);
            end
            foreach (item_tokens[i]) awaited_tokens.push_back(item_tokens[i]);
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got, time stamp);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         stamp, field, want, got);
                errors++;
            end
        endfunction

        function void check_token(t_token got, time stamp);
            t_token want;
            if (awaited_tokens.size() == 0) begin
                $display("%0t ns: token code %0d at offset %0d arrived with none awaited",
                         stamp, got.tok_code, got.start_offset);
                errors++;
                return;
            end
            want = awaited_tokens.pop_front();
            compare_field("tok_code", want.tok_code, got.tok_code, stamp);
            compare_field("start_offset", want.start_offset, got.start_offset, stamp);
            compare_field("token_length", want.token_length, got.token_length, stamp);
            compare_field("line_number", want.line_number, got.line_number, stamp);
            compare_field("column_number", want.column_number, got.column_number, stamp);
            compare_field("number_value", want.number_value, got.number_value, stamp);
            compare_field("last_of_run", want.last_of_run, got.last_of_run, stamp);
        endfunction
    endclass

endpackage

// ===== tb/byte_stream_tokenizer_tb.sv =====
// Top-level testbench for byte_stream_tokenizer: drives directed and random source
// text with random idling on both channels and checks every token.
// Depends on bst_pkg and on the token ledger in bst_tb_pkg.
module byte_stream_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bst_pkg::*;
    import bst_tb_pkg::*;

    localparam int RANDOM_ITEMS     = 1950;
    localparam int STALL_HOLD       = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES     = 20;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_kind;
    logic [7:0]          i_source_byte;
    logic                o_valid;
    logic                i_stall;
    logic [TYPE_W-1:0]   o_tok_code;
    logic [POS_W-1:0]    o_start_offset;
    logic [LEN_W-1:0]    o_token_length;
    logic [CNT_W-1:0]    o_line_number;
    logic [CNT_W-1:0]    o_column_number;
    logic [VAL_W-1:0]    o_number_value;
    logic                o_last_of_run;

    token_ledger ledger;
    bit          calm;
    bit          hold_request;
    int          idle_cycles;
    int          items_sent;

    byte_stream_tokenizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_source_byte   (i_source_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_tok_code      (o_tok_code),
        .o_start_offset  (o_start_offset),
        .o_token_length  (o_token_length),
        .o_line_number   (o_line_number),
        .o_column_number (o_column_number),
        .o_number_value  (o_number_value),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'(CH_LO_A + r);
        if (r < 52) return 8'(CH_UP_A + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic t_token read_token();
        t_token t;
        t.tok_code      = o_tok_code;
        t.start_offset  = o_start_offset;
        t.token_length  = o_token_length;
        t.line_number   = o_line_number;
        t.column_number = o_column_number;
        t.number_value  = o_number_value;
        t.last_of_run   = o_last_of_run;
        return t;
    endfunction

    // Offer one request and hold it until taken, then idle for a random gap.
    task automatic send_request(input logic kind, input logic [7:0] value);
        int gap;
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_source_byte <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        ledger.note_item(kind, value);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_request(KIND_BYTE, value);
    endtask

    task automatic send_end();
        send_request(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    endtask

    // One well-formed token with random content, noise or an end item, then maybe a blank.
    task automatic send_random_token();
        int         pick;
        string      word;
        logic [7:0] q;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_byte(punct_marks[$urandom_range(0, 7)]);
        end else if (pick < 16) begin
            send_byte($urandom_range(0, 1) ? CH_BANG : CH_EQUAL);
            if ($urandom_range(0, 1)) send_byte(CH_EQUAL);
        end else if (pick < 30) begin
            word = keyword_text[$urandom_range(0, KW_COUNT - 1)];
            case ($urandom_range(0, 5))
                0:       word = word.substr(0, word.len() - 2);
                1:       word = {word, "s"};
                default: ;
            endcase
            send_text(word);
        end else if (pick < 42) begin
            repeat ($urandom_range(1, 12)) send_byte(random_letter());
        end else if (pick < 56) begin
            case ($urandom_range(0, 4))
                0:       send_text("2147483647");
                1:       send_text("2147483648");
                2:       repeat ($urandom_range(10, 13)) send_byte(random_digit());
                default: repeat ($urandom_range(1, 6)) send_byte(random_digit());
            endcase
        end else if (pick < 66) begin
            send_text("0b");
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(29, 34) : $urandom_range(0, 8))
                send_byte($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
        end else if (pick < 76) begin
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            send_byte(q);
            repeat ($urandom_range(0, 10)) begin
                b = 8'($urandom_range(0, 255));
                if (b == q || $urandom_range(0, 7) == 0) b = CH_LF;
                send_byte(b);
            end
            if ($urandom_range(0, 9) != 0) send_byte(q);
        end else if (pick < 82) begin
            send_byte(CH_HASH);
            repeat ($urandom_range(0, 10)) begin
                b = 8'($urandom_range(0, 255));
                send_byte(b == CH_LF ? CH_SPACE : b);
            end
            if ($urandom_range(0, 6) != 0) send_byte(CH_LF);
        end else if (pick < 90) begin
            send_byte(random_blank());
        end else if (pick < 96) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_end();
        end
        if ($urandom_range(0, 9) < 6) send_byte(random_blank());
    endtask

    initial begin
        ledger        = new();
        calm          = 1'b0;
        hold_request  = 1'b0;
        items_sent    = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_BYTE;
        i_source_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every punctuation mark, the operators "!=", "=" and "!", "00b" versus "0b", binary with no
        // digits, zero and top bytes, LF in an open string, then two end items
        send_text("(){};:,$!==!00b0b ");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("'\n");
        send_end();
        send_end();

        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent > RANDOM_ITEMS / 2 && !hold_request &&
                items_sent < RANDOM_ITEMS / 2 + 40)
                hold_request = 1'b1;
            if ($urandom_range(0, 49) == 0) calm = !calm;
            send_random_token();
        end

        calm = 1'b0;
        repeat (40) send_random_token();
        send_end();
        i_valid <= 1'b0;

        while (ledger.awaited_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.awaited_tokens.size() == 0) begin
            $display("byte_stream_tokenizer_tb: PASS");
        end else begin
            $display("byte_stream_tokenizer_tb: FAIL");
        end
        $finish;
    end

    // Result side: check taken tokens, stall at random, serve the long hold once.
    initial begin
        int hold_cycles;
        bit hold_done;
        hold_cycles = 0;
        hold_done   = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall) ledger.check_token(read_token(), $time);
            if (hold_request && !hold_done) begin
                hold_cycles = STALL_HOLD;
                hold_done   = 1'b1;
            end else if (hold_cycles == 0 && !calm) begin
                hold_cycles = pick_stall();
            end
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("byte_stream_tokenizer_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
